// ===== src/emgwl_pkg.sv =====
// shared types, constants and helper functions of the emg window level trigger
// no dependencies; every other file takes names from here by scope
package emgwl_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = 14;
    localparam int LEN_W       = 7;
    localparam int THR_W       = 8;
    localparam int MEAN_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int WIN_MAX     = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CH_SHIFT    = $clog2(CHANNELS);
    localparam int TOTAL_W     = SUM_W + CH_SHIFT;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int IN_DATA_W   = CHANNELS * SAMPLE_W;
    localparam int OUT_DATA_W  = 96;

    localparam logic [LEN_W-1:0]   WINDOW_LEN_RESET = 7'd38;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 8'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_DONE
    } back_state_t;

    typedef enum logic {
        REG_WINDOW_LEN      = 1'b0,
        REG_LEVEL_THRESHOLD = 1'b1
    } reg_index_t;

    // one closed window waiting for the divider
    typedef struct packed {
        logic [CHANNELS-1:0][SUM_W-1:0] sums;
        logic [LEN_W-1:0]               len;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [CHANNELS-1:0][MEAN_W-1:0] means;
        logic [MEAN_W-1:0]               level;
        logic                            triggered;
        logic [COUNT_W-1:0]              count;
    } result_t;

    // absolute value, -128 gives 128 as an unsigned byte
    function automatic logic [SAMPLE_W-1:0] rectify(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] neg;
        neg = ~raw + SAMPLE_W'(1);
        return raw[SAMPLE_W-1] ? neg : raw;
    endfunction

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [LEN_W-1:0] effective_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] res;
        if (raw == '0) begin
            res = LEN_W'(1);
        end else if (raw > LEN_W'(WIN_MAX)) begin
            res = LEN_W'(WIN_MAX);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

// ===== src/emgwl_front.sv =====
// front end: accepts samples, rectifies and accumulates per channel
// pushes closed windows into the job queue; uses emgwl_pkg
module emgwl_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [emgwl_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [emgwl_pkg::LEN_W-1:0]           window_len,
    input  emgwl_pkg::queue_status_t              q_status,
    output logic                                  push,
    output emgwl_pkg::job_t                       push_job
);

    logic [emgwl_pkg::CHANNELS-1:0][emgwl_pkg::SUM_W-1:0] sums_reg, sums_next, sums_add;
    logic [emgwl_pkg::LEN_W-1:0] count_reg, count_next, count_inc, eff_len;
    logic accept, close;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign eff_len  = emgwl_pkg::effective_len(window_len);

    always_comb begin
        for (int i = 0; i < emgwl_pkg::CHANNELS; i++) begin
            sums_add[i] = sums_reg[i] + emgwl_pkg::SUM_W'(emgwl_pkg::rectify(
                s_tdata[i*emgwl_pkg::SAMPLE_W +: emgwl_pkg::SAMPLE_W]));
        end
        count_inc = count_reg + emgwl_pkg::LEN_W'(1);
        close     = count_inc >= eff_len;

        sums_next  = sums_reg;
        count_next = count_reg;
        push       = 1'b0;
        if (accept) begin
            if (close) begin
                sums_next  = '0;
                count_next = '0;
                push       = 1'b1;
            end else begin
                sums_next  = sums_add;
                count_next = count_inc;
            end
        end
        push_job.sums = sums_add;
        push_job.len  = eff_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg  <= '0;
            count_reg <= '0;
        end else begin
            sums_reg  <= sums_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/emgwl_queue.sv =====
// short job queue between front and back ends
// register based fifo of emgwl_pkg::job_t entries
module emgwl_queue #(
    parameter int DEPTH = emgwl_pkg::QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  emgwl_pkg::job_t          push_job,
    input  logic                     pop,
    output emgwl_pkg::job_t          pop_job,
    output emgwl_pkg::queue_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    emgwl_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_status.full  = cnt_reg == CNT_W'(DEPTH);
    assign q_status.empty = cnt_reg == '0;
    assign pop_job        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_status.full))
        else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_status.empty))
        else $error("job popped from empty queue");
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !q_status.empty)
        else $error("queue empty after push");
`endif

endmodule

// ===== src/emgwl_back.sv =====
// back end: eight radix-2 divider lanes share the window length,
// then level, trigger edge count and the output register; uses emgwl_pkg
module emgwl_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  emgwl_pkg::queue_status_t       q_status,
    input  emgwl_pkg::job_t                pop_job,
    output logic                           pop,
    input  logic [emgwl_pkg::THR_W-1:0]    level_threshold,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output emgwl_pkg::result_t             result
);

    localparam int CH    = emgwl_pkg::CHANNELS;
    localparam int SUM_W = emgwl_pkg::SUM_W;
    localparam int LEN_W = emgwl_pkg::LEN_W;

    emgwl_pkg::back_state_t state_reg, state_next;
    logic [CH-1:0][SUM_W-1:0] quot_reg, quot_next;
    logic [CH-1:0][LEN_W-1:0] rem_reg, rem_next, trial;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [emgwl_pkg::STEP_W-1:0] step_reg, step_next;
    logic [emgwl_pkg::TOTAL_W-1:0] total;
    logic [SUM_W-1:0] level;
    logic trig, load_out, valid_reg, valid_next, was_trig_reg, was_trig_next;
    logic [emgwl_pkg::COUNT_W-1:0] edge_cnt_reg, edge_cnt_next;
    emgwl_pkg::result_t result_reg, result_next;

    assign m_tvalid = valid_reg;
    assign result   = result_reg;

    always_comb begin
        total = '0;
        for (int i = 0; i < CH; i++) begin
            total = total + emgwl_pkg::TOTAL_W'(quot_reg[i]);
        end
        level = total[emgwl_pkg::TOTAL_W-1:emgwl_pkg::CH_SHIFT];
        trig  = level >= SUM_W'(level_threshold);

        // one restoring step in every lane
        for (int i = 0; i < CH; i++) begin
            trial[i] = {rem_reg[i][LEN_W-2:0], quot_reg[i][SUM_W-1]};
        end

        state_next    = state_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        len_next      = len_reg;
        step_next     = step_reg;
        pop           = 1'b0;
        load_out      = 1'b0;
        valid_next    = valid_reg && !m_tready;
        was_trig_next = was_trig_reg;
        edge_cnt_next = edge_cnt_reg;
        result_next   = result_reg;

        case (state_reg)
            emgwl_pkg::BACK_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    quot_next  = pop_job.sums;
                    rem_next   = '0;
                    len_next   = pop_job.len;
                    step_next  = '0;
                    state_next = emgwl_pkg::BACK_DIV;
                end
            end
            emgwl_pkg::BACK_DIV: begin
                for (int i = 0; i < CH; i++) begin
                    if (trial[i] >= len_reg) begin
                        rem_next[i]  = trial[i] - len_reg;
                        quot_next[i] = {quot_reg[i][SUM_W-2:0], 1'b1};
                    end else begin
                        rem_next[i]  = trial[i];
                        quot_next[i] = {quot_reg[i][SUM_W-2:0], 1'b0};
                    end
                end
                step_next = step_reg + emgwl_pkg::STEP_W'(1);
                if (step_reg == emgwl_pkg::STEP_W'(SUM_W - 1)) begin
                    state_next = emgwl_pkg::BACK_DONE;
                end
            end
            emgwl_pkg::BACK_DONE: begin
                // wait for a free output register
                if (!valid_reg || m_tready) begin
                    load_out      = 1'b1;
                    valid_next    = 1'b1;
                    was_trig_next = trig;
                    if (trig && !was_trig_reg && edge_cnt_reg != emgwl_pkg::COUNT_MAX) begin
                        edge_cnt_next = edge_cnt_reg + emgwl_pkg::COUNT_W'(1);
                    end
                    for (int i = 0; i < CH; i++) begin
                        result_next.means[i] = quot_reg[i][emgwl_pkg::MEAN_W-1:0];
                    end
                    result_next.level     = level[emgwl_pkg::MEAN_W-1:0];
                    result_next.triggered = trig;
                    result_next.count     = edge_cnt_next;
                    state_next            = emgwl_pkg::BACK_IDLE;
                end
            end
            default: begin
                state_next = emgwl_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= emgwl_pkg::BACK_IDLE;
            valid_reg    <= 1'b0;
            was_trig_reg <= 1'b0;
            edge_cnt_reg <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            was_trig_reg <= was_trig_next;
            edge_cnt_reg <= edge_cnt_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        len_reg  <= len_next;
        if (load_out) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/emg_window_level_trigger.sv =====
// path: the window-closing sample pushes a job into the queue; the back pops it, runs the
//   14-step shared-divisor divider and loads the output register, which sets m_tvalid
// throughput: one sample per cycle into the front while the job queue is not full; the back
//   pops a new window only after the output load of the last one
// a two-entry job queue lets the front keep taking samples while the back divides
// reset (aresetn, synchronous, active low): accumulators, counts, queue and trigger state
//   clear; window_len returns to 38 and level_threshold to 12
module emg_window_level_trigger #(
    parameter int QUEUE_DEPTH = emgwl_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ch0 [7:0], ch1, ch2, ch3, ch4, ch5, ch6, ch7 [63:56], signed
    input  logic [emgwl_pkg::IN_DATA_W-1:0]     s_tdata,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean0 [7:0] .. mean7 [63:56], overall_level [71:64], triggered [72],
    // trigger_count [88:73], zero [95:89]
    output logic [emgwl_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [emgwl_pkg::LEN_W-1:0] window_len_reg;
    logic [emgwl_pkg::THR_W-1:0] level_threshold_reg;
    logic cfg_write;
    emgwl_pkg::reg_index_t cfg_index;

    logic push, pop;
    emgwl_pkg::job_t push_job, pop_job;
    emgwl_pkg::queue_status_t q_status;
    emgwl_pkg::result_t result;

    // register file: window length at 0x0, threshold at 0x4
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = emgwl_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg      <= emgwl_pkg::WINDOW_LEN_RESET;
            level_threshold_reg <= emgwl_pkg::THRESHOLD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                emgwl_pkg::REG_WINDOW_LEN: begin
                    window_len_reg <= pwdata[emgwl_pkg::LEN_W-1:0];
                end
                emgwl_pkg::REG_LEVEL_THRESHOLD: begin
                    level_threshold_reg <= pwdata[emgwl_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            emgwl_pkg::REG_WINDOW_LEN:      prdata = 32'(window_len_reg);
            emgwl_pkg::REG_LEVEL_THRESHOLD: prdata = 32'(level_threshold_reg);
            default:                        prdata = '0;
        endcase
    end

    // front: rectify and accumulate, hand closed windows to the queue
    emgwl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .window_len (window_len_reg),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    emgwl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    // back: divide, level, trigger edge count, output register
    emgwl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_status        (q_status),
        .pop_job         (pop_job),
        .pop             (pop),
        .level_threshold (level_threshold_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .result          (result)
    );

    // pack result fields, first field lowest
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < emgwl_pkg::CHANNELS; i++) begin
            m_tdata[i*emgwl_pkg::MEAN_W +: emgwl_pkg::MEAN_W] = result.means[i];
        end
        m_tdata[64 +: emgwl_pkg::MEAN_W]  = result.level;
        m_tdata[72]                       = result.triggered;
        m_tdata[73 +: emgwl_pkg::COUNT_W] = result.count;
    end

endmodule
